FILE: rtl/pnn_pkg.sv
// Shared types and constants of the streaming polygon normal block.
// Used by every module of the block; depends on nothing else.
package pnn_pkg;

	// Field and datapath widths.
	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int TERM_W    = 2 * DIFF_W;
	localparam int ACC_W     = 44;
	localparam int LIM_W     = 21;
	localparam int NORM_W    = 16;
	localparam int MAG_W     = ACC_W;
	localparam int HALF_W    = MAG_W / 2;
	localparam int PROD_W    = 2 * HALF_W;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int REM_W     = SQ_W + 1;
	localparam int QUO_W     = 31;
	localparam int ROOT_W    = 16;
	localparam int STEP_W    = 5;

	// Vertex limit per polygon and the depth of the queue between front and back.
	localparam int MAX_VERTICES_DEF = 256;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [ACC_W-1:0] acc_t;

	// One closed polygon's Newell sum, orientation already applied.
	typedef struct packed {
		acc_t x;
		acc_t y;
		acc_t z;
	} sum_vec_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic              not_empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

FILE: rtl/pnn_front.sv
// Front end: accepts vertices, forms Newell cross terms and accumulates them.
// Depends on pnn_pkg; pushes one closed sum per polygon into pnn_queue.
module pnn_front #(
	parameter int MAX_VERTICES = pnn_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pnn_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [pnn_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [pnn_pkg::COORD_W-1:0]  pos_z,
	input  logic                                last_vertex,
	input  logic                                clockwise,
	input  pnn_pkg::qstat_t                     qstat,
	output logic                                push,
	output pnn_pkg::sum_vec_t                   push_data
);

	localparam int VCNT_W = $clog2(MAX_VERTICES);

	logic signed [pnn_pkg::COORD_W-1:0] cur [3];
	logic signed [pnn_pkg::COORD_W-1:0] prev_q [3];
	logic signed [pnn_pkg::COORD_W-1:0] first_q [3];
	logic [VCNT_W-1:0]                  cnt_q;
	logic                               face_start_q;
	logic                               accept;
	logic                               close;

	logic                               valid_s1, first_s1, close_s1, cw_s1;
	logic signed [pnn_pkg::DIFF_W-1:0]  pd_s1 [3];
	logic signed [pnn_pkg::DIFF_W-1:0]  ps_s1 [3];
	logic signed [pnn_pkg::DIFF_W-1:0]  cd_s1 [3];
	logic signed [pnn_pkg::DIFF_W-1:0]  cs_s1 [3];

	logic                               valid_s2, first_s2, close_s2, cw_s2;
	logic signed [pnn_pkg::TERM_W-1:0]  tp_s2 [3];
	logic signed [pnn_pkg::TERM_W-1:0]  tc_s2 [3];

	pnn_pkg::acc_t                      acc_q [3];
	pnn_pkg::acc_t                      acc_new [3];
	logic [pnn_pkg::QCNT_W:0]           reserved;

	assign cur[0] = pos_x;
	assign cur[1] = pos_y;
	assign cur[2] = pos_z;

	// Room must remain in the queue for every closing vertex still in flight.
	assign reserved = {1'b0, qstat.count}
		+ (pnn_pkg::QCNT_W + 1)'(valid_s1 & close_s1)
		+ (pnn_pkg::QCNT_W + 1)'(valid_s2 & close_s2);
	assign in_ready = reserved < (pnn_pkg::QCNT_W + 1)'(pnn_pkg::QUEUE_DEPTH);
	assign accept   = in_valid & in_ready;
	assign close    = last_vertex | (cnt_q == VCNT_W'(MAX_VERTICES - 1));

	// Vertex bookkeeping: first and previous vertex, count of the open polygon.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			face_start_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				prev_q[i]  <= '0;
				first_q[i] <= '0;
			end
		end else if (accept) begin
			cnt_q        <= close ? '0 : cnt_q + VCNT_W'(1);
			face_start_q <= close;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= cur[i];
				if (face_start_q) begin
					first_q[i] <= cur[i];
				end
			end
		end
	end

	// Stage 1: differences and sums of the edge to the previous vertex and the closing edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= face_start_q;
			close_s1 <= close;
			cw_s1    <= clockwise;
			for (int i = 0; i < 3; i++) begin
				if (face_start_q) begin
					pd_s1[i] <= '0;
					ps_s1[i] <= '0;
				end else begin
					pd_s1[i] <= pnn_pkg::DIFF_W'(prev_q[i]) - pnn_pkg::DIFF_W'(cur[i]);
					ps_s1[i] <= pnn_pkg::DIFF_W'(prev_q[i]) + pnn_pkg::DIFF_W'(cur[i]);
				end
				if (close && !face_start_q) begin
					cd_s1[i] <= pnn_pkg::DIFF_W'(cur[i]) - pnn_pkg::DIFF_W'(first_q[i]);
					cs_s1[i] <= pnn_pkg::DIFF_W'(cur[i]) + pnn_pkg::DIFF_W'(first_q[i]);
				end else begin
					cd_s1[i] <= '0;
					cs_s1[i] <= '0;
				end
			end
		end
	end

	// Stage 2: the cross-term products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			first_s2 <= first_s1;
			close_s2 <= close_s1;
			cw_s2    <= cw_s1;
			tp_s2[0] <= pnn_pkg::TERM_W'(pd_s1[1]) * pnn_pkg::TERM_W'(ps_s1[2]);
			tp_s2[1] <= pnn_pkg::TERM_W'(pd_s1[2]) * pnn_pkg::TERM_W'(ps_s1[0]);
			tp_s2[2] <= pnn_pkg::TERM_W'(pd_s1[0]) * pnn_pkg::TERM_W'(ps_s1[1]);
			tc_s2[0] <= pnn_pkg::TERM_W'(cd_s1[1]) * pnn_pkg::TERM_W'(cs_s1[2]);
			tc_s2[1] <= pnn_pkg::TERM_W'(cd_s1[2]) * pnn_pkg::TERM_W'(cs_s1[0]);
			tc_s2[2] <= pnn_pkg::TERM_W'(cd_s1[0]) * pnn_pkg::TERM_W'(cs_s1[1]);
		end
	end

	// Accumulate; a new polygon starts from zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_new[i] = (first_s2 ? pnn_pkg::acc_t'(0) : acc_q[i])
				+ pnn_pkg::ACC_W'(tp_s2[i]) + pnn_pkg::ACC_W'(tc_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else if (valid_s2) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= acc_new[i];
			end
		end
	end

	// A closed polygon leaves with its orientation applied.
	assign push        = valid_s2 & close_s2;
	assign push_data.x = cw_s2 ? -acc_new[0] : acc_new[0];
	assign push_data.y = cw_s2 ? -acc_new[1] : acc_new[1];
	assign push_data.z = cw_s2 ? -acc_new[2] : acc_new[2];

endmodule

FILE: rtl/pnn_queue.sv
// Short queue of closed polygon sums between the front and the back end.
// Depends on pnn_pkg for the entry type and depth.
module pnn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pnn_pkg::sum_vec_t push_data,
	input  logic              pop,
	output pnn_pkg::sum_vec_t deq_data,
	output pnn_pkg::qstat_t   qstat
);

	pnn_pkg::sum_vec_t           mem [pnn_pkg::QUEUE_DEPTH];
	logic [pnn_pkg::QPTR_W-1:0]  wr_q, rd_q;
	logic [pnn_pkg::QCNT_W-1:0]  cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + pnn_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + pnn_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + pnn_pkg::QCNT_W'(push) - pnn_pkg::QCNT_W'(pop);
		end
	end

	assign deq_data        = mem[rd_q];
	assign qstat.count     = cnt_q;
	assign qstat.not_empty = cnt_q != '0;

endmodule

FILE: rtl/pnn_back.sv
// Back end: squares, length test, and per-component division and square root.
// Depends on pnn_pkg; takes sums from pnn_queue and drives the output register.
module pnn_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pnn_pkg::qstat_t                    qstat,
	input  pnn_pkg::sum_vec_t                  deq_data,
	output logic                               pop,
	input  logic [pnn_pkg::LIM_W-1:0]          limit,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pnn_pkg::NORM_W-1:0]  normal_x,
	output logic signed [pnn_pkg::NORM_W-1:0]  normal_y,
	output logic signed [pnn_pkg::NORM_W-1:0]  normal_z,
	output logic                               degenerate
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQUARE, ST_LIMSQ, ST_START, ST_DIV, ST_SQRT, ST_NEXT, ST_DONE
	} state_t;

	state_t                          state_q;
	logic [pnn_pkg::MAG_W-1:0]       mag_q [3];
	logic                            neg_q [3];
	logic [pnn_pkg::SQ_W-1:0]        msq_q [3];
	logic [pnn_pkg::SQ_W-1:0]        sq_q;
	logic [1:0]                      comp_q, part_q;
	logic [pnn_pkg::STEP_W-1:0]      step_q;
	logic [pnn_pkg::REM_W-1:0]       rem_q;
	logic [pnn_pkg::QUO_W-1:0]       quo_q;
	logic [pnn_pkg::ROOT_W-1:0]      root_q;
	logic [pnn_pkg::NORM_W-1:0]      res_q [3];
	logic                            deg_q;

	logic [pnn_pkg::HALF_W-1:0]      mul_a, mul_b, hi, lo;
	logic [pnn_pkg::PROD_W-1:0]      prod;
	logic [pnn_pkg::SQ_W-1:0]        part_add;
	logic [pnn_pkg::REM_W-1:0]       r_sh;
	logic [pnn_pkg::ROOT_W-1:0]      trial;
	logic [pnn_pkg::NORM_W-1:0]      qmag;
	pnn_pkg::acc_t                   c_in [3];

	assign c_in[0] = deq_data.x;
	assign c_in[1] = deq_data.y;
	assign c_in[2] = deq_data.z;

	assign pop = (state_q == ST_IDLE) && qstat.not_empty;

	// Shared multiplier: square partials, the limit square and the root trials.
	assign hi    = mag_q[comp_q][pnn_pkg::MAG_W-1:pnn_pkg::HALF_W];
	assign lo    = mag_q[comp_q][pnn_pkg::HALF_W-1:0];
	assign trial = root_q | (pnn_pkg::ROOT_W'(1) << step_q[3:0]);

	always_comb begin
		mul_a    = lo;
		mul_b    = lo;
		part_add = '0;
		unique case (state_q)
			ST_SQUARE: begin
				unique case (part_q)
					2'd0: begin
						mul_a    = hi;
						mul_b    = hi;
						part_add = pnn_pkg::SQ_W'(prod) << (2 * pnn_pkg::HALF_W);
					end
					2'd1: begin
						mul_a    = hi;
						mul_b    = lo;
						part_add = pnn_pkg::SQ_W'(prod) << (pnn_pkg::HALF_W + 1);
					end
					default: begin
						part_add = pnn_pkg::SQ_W'(prod);
					end
				endcase
			end
			ST_LIMSQ: begin
				mul_a = pnn_pkg::HALF_W'(limit);
				mul_b = pnn_pkg::HALF_W'(limit);
			end
			ST_SQRT: begin
				mul_a = pnn_pkg::HALF_W'(trial);
				mul_b = pnn_pkg::HALF_W'(trial);
			end
			default: begin
			end
		endcase
	end

	assign prod = pnn_pkg::PROD_W'(mul_a) * pnn_pkg::PROD_W'(mul_b);

	// Division step: the first step takes the square itself, later ones double.
	assign r_sh = (step_q == pnn_pkg::STEP_W'(pnn_pkg::QUO_W - 1)) ? rem_q
		: {rem_q[pnn_pkg::REM_W-2:0], 1'b0};

	// The root saturates at one below +1.
	assign qmag = root_q[pnn_pkg::ROOT_W-1] ? pnn_pkg::NORM_W'(16'h7fff) : root_q;

	// Sequencer of one polygon's back-end work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (qstat.not_empty) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= c_in[i][pnn_pkg::ACC_W-1] ? pnn_pkg::MAG_W'(-c_in[i])
								: pnn_pkg::MAG_W'(c_in[i]);
							neg_q[i] <= c_in[i][pnn_pkg::ACC_W-1];
							msq_q[i] <= '0;
						end
						sq_q    <= '0;
						comp_q  <= '0;
						part_q  <= '0;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					msq_q[comp_q] <= msq_q[comp_q] + part_add;
					sq_q          <= sq_q + part_add;
					if (part_q == 2'd2) begin
						part_q <= '0;
						if (comp_q == 2'd2) begin
							state_q <= ST_LIMSQ;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				ST_LIMSQ: begin
					comp_q <= '0;
					if (sq_q < pnn_pkg::SQ_W'(prod)) begin
						deg_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							res_q[i] <= '0;
						end
						state_q <= ST_DONE;
					end else begin
						deg_q   <= 1'b0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (mag_q[comp_q] == '0) begin
						res_q[comp_q] <= '0;
						state_q       <= ST_NEXT;
					end else begin
						rem_q   <= pnn_pkg::REM_W'(msq_q[comp_q]);
						quo_q   <= '0;
						step_q  <= pnn_pkg::STEP_W'(pnn_pkg::QUO_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (r_sh >= pnn_pkg::REM_W'(sq_q)) begin
						rem_q <= r_sh - pnn_pkg::REM_W'(sq_q);
						quo_q <= {quo_q[pnn_pkg::QUO_W-2:0], 1'b1};
					end else begin
						rem_q <= r_sh;
						quo_q <= {quo_q[pnn_pkg::QUO_W-2:0], 1'b0};
					end
					if (step_q == '0) begin
						root_q  <= '0;
						step_q  <= pnn_pkg::STEP_W'(pnn_pkg::ROOT_W - 1);
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q - pnn_pkg::STEP_W'(1);
					end
				end
				ST_SQRT: begin
					if (prod <= pnn_pkg::PROD_W'(quo_q)) begin
						root_q <= trial;
					end
					if (step_q == '0) begin
						state_q <= ST_NEXT;
					end else begin
						step_q <= step_q - pnn_pkg::STEP_W'(1);
					end
				end
				ST_NEXT: begin
					if (mag_q[comp_q] != '0) begin
						res_q[comp_q] <= neg_q[comp_q] ? -qmag : qmag;
					end
					if (comp_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= ST_START;
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						normal_x   <= res_q[0];
						normal_y   <= res_q[1];
						normal_z   <= res_q[2];
						degenerate <= deg_q;
						out_valid  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/polygon_normal_newell.sv
// Top level of the streaming polygon normal block.
// Depends on pnn_pkg, pnn_front, pnn_queue and pnn_back.
//
// Vertices enter on the in_valid/in_ready channel, one transaction per vertex,
// with last_vertex marking the end of a polygon (a polygon of MAX_VERTICES
// vertices closes on its own). clockwise is sampled at the closing vertex.
// The front end takes one vertex per cycle while the queue has room; each
// closed polygon yields one transaction on out_valid/out_ready carrying the
// Q1.15 unit normal and the degenerate flag.
// The closed sum enters the queue once the closing vertex has passed stage 1
// and stage 2 of the front end. The back end then pops it, forms nine partial
// squares and makes the length test; for each nonzero component it sets up,
// runs 31 quotient steps and 16 root steps on one shared 22x22 multiplier and
// writes back; last it loads the output register. A degenerate face skips
// the divisions and roots. Polygon throughput is set by that back end; vertex
// throughput is one per cycle until the four-entry queue of closed sums,
// counting closing vertices still in flight, is full.
// The cfg_valid/cfg_ready channel writes the limit register limit_q; cfg_ready is high.
// Reset clears all control state, sets the limit to 1 and starts a new polygon.
// A stalled receiver holds the result in the output register; the back end
// then waits, the queue fills, and in_ready drops.
module polygon_normal_newell #(
	parameter int MAX_VERTICES = pnn_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pnn_pkg::COORD_W-1:0] pos_x,
	input  logic signed [pnn_pkg::COORD_W-1:0] pos_y,
	input  logic signed [pnn_pkg::COORD_W-1:0] pos_z,
	input  logic                               last_vertex,
	input  logic                               clockwise,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pnn_pkg::NORM_W-1:0]  normal_x,
	output logic signed [pnn_pkg::NORM_W-1:0]  normal_y,
	output logic signed [pnn_pkg::NORM_W-1:0]  normal_z,
	output logic                               degenerate,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pnn_pkg::LIM_W-1:0]          cfg_data
);

	logic                        push, pop;
	pnn_pkg::sum_vec_t           push_data, deq_data;
	pnn_pkg::qstat_t             qstat;
	logic [pnn_pkg::LIM_W-1:0]   limit_q;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pnn_pkg::LIM_W'(1);
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	pnn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .pos_x, .pos_y, .pos_z,
		.last_vertex, .clockwise, .qstat, .push, .push_data
	);

	pnn_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .deq_data, .qstat
	);

	pnn_back u_back (
		.clk, .arst_n, .qstat, .deq_data, .pop, .limit(limit_q),
		.out_valid, .out_ready, .normal_x, .normal_y, .normal_z, .degenerate
	);

endmodule

FILE: rtl/pnn_checker.sv
// Port-level checks of the polygon normal block, bound to its top level.
// Depends on pnn_pkg and polygon_normal_newell.
module pnn_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [pnn_pkg::NORM_W-1:0]  normal_x,
	input logic signed [pnn_pkg::NORM_W-1:0]  normal_y,
	input logic signed [pnn_pkg::NORM_W-1:0]  normal_z,
	input logic                               degenerate,
	input logic                               cfg_ready
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(normal_x)
			&& $stable(normal_y) && $stable(normal_z) && $stable(degenerate))
		else $error("stalled result changed");

	// A degenerate face carries a zero normal.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate face with nonzero normal");

	// Components saturate below +1, so the most negative code never appears.
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x != 16'sh8000 && normal_y != 16'sh8000
			&& normal_z != 16'sh8000)
		else $error("normal component out of Q1.15 range");

	// The configuration port never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind polygon_normal_newell pnn_checker u_pnn_checker (
	.clk, .arst_n, .out_valid, .out_ready, .normal_x, .normal_y, .normal_z,
	.degenerate, .cfg_ready
);
